[rtl/iopdu_pkg.sv]
// ----------------------------------------------------------------------------
// iopdu_pkg
// Types, codes and the fixed drive geometry of the disk/uart i/o port device.
// ----------------------------------------------------------------------------
`default_nettype none

package iopdu_pkg;

   // item modes
   localparam logic [1:0] MODE_BUS_READ  = 2'd0;
   localparam logic [1:0] MODE_BUS_WRITE = 2'd1;
   localparam logic [1:0] MODE_UART_RX   = 2'd2;
   localparam logic [1:0] MODE_XFER_DONE = 2'd3;

   // bus ports
   localparam logic [3:0] PORT_STATUS    = 4'd0;
   localparam logic [3:0] PORT_DRIVE     = 4'd1;
   localparam logic [3:0] PORT_TRACK     = 4'd2;
   localparam logic [3:0] PORT_SECT_LO   = 4'd3;
   localparam logic [3:0] PORT_SECT_HI   = 4'd4;
   localparam logic [3:0] PORT_OFF_LO    = 4'd5;
   localparam logic [3:0] PORT_OFF_HI    = 4'd6;
   localparam logic [3:0] PORT_SEG_LO    = 4'd7;
   localparam logic [3:0] PORT_SEG_HI    = 4'd8;
   localparam logic [3:0] PORT_UART_ST   = 4'd9;
   localparam logic [3:0] PORT_UART_DATA = 4'd10;
   localparam logic [3:0] PORT_NMI_OFF   = 4'd11;

   // disk commands
   localparam logic [7:0] CMD_READ  = 8'h00;
   localparam logic [7:0] CMD_WRITE = 8'h01;

   // disk status codes
   localparam logic [7:0] ST_READY = 8'h00;
   localparam logic [7:0] ST_ERROR = 8'h01;
   localparam logic [7:0] ST_READ  = 8'h02;
   localparam logic [7:0] ST_WRITE = 8'h04;
   localparam logic [7:0] ST_BUSY  = 8'h80;

   localparam logic [7:0] RDATA_UNMAPPED = 8'hff;
   localparam logic [7:0] ICHAR_RESET    = 8'd17;

   // configuration port
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic        CSR_IDX_ICHAR = 1'b0;

   // sectors per track
   localparam int unsigned SPT_W = 15;
   localparam logic [SPT_W-1:0] SPT_FLOPPY = 15'd26;
   localparam logic [SPT_W-1:0] SPT_HD     = 15'd128;
   localparam logic [SPT_W-1:0] SPT_BIG    = 15'd16484;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [3:0] port;
      logic [7:0] wdata;
      logic       tx_ready;
      logic       done_ok;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  rdata;
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        nmi_raise;
      logic        nmi_lower;
      logic        xfer_request;
      logic        xfer_write;
      logic [7:0]  xfer_drive;
      logic [31:0] xfer_lba;
      logic [20:0] xfer_dma_addr;
   } rsp_payload_type;

   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctl_type;

   typedef struct packed {
      logic nonempty;
      logic full;
   } fifo_stat_type;

   function automatic logic [SPT_W-1:0] geometry(input logic [3:0] drive);
      logic [SPT_W-1:0] spt;
      case (drive) inside
         [4'd0:4'd3]:  spt = SPT_FLOPPY;
         [4'd8:4'd11]: spt = SPT_HD;
         4'd15:        spt = SPT_BIG;
         default:      spt = '0;
      endcase
      return spt;
   endfunction

endpackage

`default_nettype wire

[rtl/iopdu_if.sv]
// ----------------------------------------------------------------------------
// iopdu channel interfaces
// Valid/ready channels for the request and response beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface iopdu_req_if;
   logic                      valid;
   logic                      ready;
   iopdu_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface iopdu_rsp_if;
   logic                      valid;
   logic                      ready;
   iopdu_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/iopdu_rx_fifo.sv]
// ----------------------------------------------------------------------------
// iopdu_rx_fifo
// Uart receive fifo: byte memory with head/tail pointers and a fill count,
// read data registered from the tail entry every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module iopdu_rx_fifo #(
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire iopdu_pkg::fifo_ctl_type  ctl,
   input  wire logic [7:0]               wdata,
   output      logic [7:0]               rdata,
   output      iopdu_pkg::fifo_stat_type stat
);

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [7:0]       mem [DEPTH];
   logic [7:0]       rdata_ff;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign stat.nonempty = (count_ff != '0);
   assign stat.full     = (count_ff == FULL_CNT);
   assign do_push       = ctl.push && !stat.full;
   assign do_pop        = ctl.pop && stat.nonempty;
   assign rdata         = rdata_ff;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         head_in = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
      end
      if (do_pop) begin
         tail_in = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // storage: one write, one registered read at the tail
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[head_ff] <= wdata;
      end
      rdata_ff <= mem[tail_ff];
   end

endmodule

`default_nettype wire

[rtl/io_port_disk_uart_controller_top.sv]
// ----------------------------------------------------------------------------
// io_port_disk_uart_controller_top
// 8088 i/o port device: disk command/status registers, dma address and lba
// generation, uart transmit pass-through and a uart receive fifo.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          carries
//  req_chan  in   valid/ready        mode, port, wdata, tx_ready, done_ok
//  rsp_chan  out  valid/ready        bus read data, tx, nmi, transfer request
//  csr_*     in   apb, pready high   interrupt_char at byte address 0
//
//  each item is accepted, then executed with the fifo tail byte read from
//  its memory in the accept cycle through a registered memory read.
//  the result sits in an output register; a new beat is accepted while it
//  waits, but execution stalls until the previous result has been taken.
//  synchronous reset clears control and register state but item_ff and rsp_ff.
// ----------------------------------------------------------------------------
`default_nettype none

module io_port_disk_uart_controller_top #(
   parameter int unsigned RX_DEPTH    = 256,
   parameter int unsigned DRIVE_COUNT = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   iopdu_req_if.sink                             req_chan,
   iopdu_rsp_if.source                           rsp_chan,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [iopdu_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [iopdu_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output      logic [iopdu_pkg::CSR_DATA_W-1:0] csr_prdata,
   output      logic                             csr_pready
);

   iopdu_pkg::state_type       state_ff, state_in;
   iopdu_pkg::req_payload_type item_ff;
   iopdu_pkg::rsp_payload_type rsp_ff, rsp_in;
   iopdu_pkg::fifo_ctl_type    fifo_ctl;
   iopdu_pkg::fifo_stat_type   fifo_stat;

   logic        rsp_valid_ff;
   logic        req_ready;
   logic        commit;
   logic [7:0]  fifo_rdata;
   logic [7:0]  ichar_ff;
   logic [7:0]  status_ff, status_in;
   logic [7:0]  drive_ff, drive_in;
   logic [7:0]  track_ff, track_in;
   logic [15:0] sector_ff, sector_in;
   logic [15:0] offset_ff, offset_in;
   logic [15:0] segment_ff, segment_in;

   logic                        drive_known;
   logic                        is_busy;
   logic [iopdu_pkg::SPT_W-1:0] spt;
   logic [22:0]                 lba_prod;
   logic [31:0]                 lba;
   logic [20:0]                 dma_addr;

   // ------------------------------------------------------------ csr port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == iopdu_pkg::CSR_IDX_ICHAR) ?
                       iopdu_pkg::CSR_DATA_W'(ichar_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         ichar_ff <= iopdu_pkg::ICHAR_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == iopdu_pkg::CSR_IDX_ICHAR) begin
         ichar_ff <= csr_pwdata[7:0];
      end
   end

   // ------------------------------------------------------------ sequencer
   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      commit    = 1'b0;
      case (state_ff)
         iopdu_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_chan.valid) begin
               state_in = iopdu_pkg::ST_EXEC;
            end
         end
         iopdu_pkg::ST_EXEC: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_chan.ready) begin
               commit   = 1'b1;
               state_in = iopdu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = iopdu_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iopdu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_ready) begin
         item_ff <= req_chan.payload;
      end
   end

   // ------------------------------------------------------------ datapath
   assign is_busy     = (status_ff & iopdu_pkg::ST_BUSY) != '0;
   assign drive_known = ({1'b0, drive_ff} < 9'(DRIVE_COUNT)) && (drive_ff < 8'd16);
   assign spt         = drive_known ? iopdu_pkg::geometry(drive_ff[3:0]) : '0;
   assign lba_prod    = 23'(track_ff) * 23'(spt);
   assign lba         = 32'(lba_prod) + 32'(sector_ff) - 32'd1;
   assign dma_addr    = 21'({segment_ff, 4'b0000}) + 21'(offset_ff);

   always_comb begin
      rsp_in     = '0;
      fifo_ctl   = '0;
      status_in  = status_ff;
      drive_in   = drive_ff;
      track_in   = track_ff;
      sector_in  = sector_ff;
      offset_in  = offset_ff;
      segment_in = segment_ff;
      case (item_ff.mode)
         iopdu_pkg::MODE_BUS_READ: begin
            case (item_ff.port)
               iopdu_pkg::PORT_STATUS: begin
                  rsp_in.rdata = status_ff;
               end
               iopdu_pkg::PORT_UART_ST: begin
                  rsp_in.rdata = {6'b000000, item_ff.tx_ready, fifo_stat.nonempty};
               end
               iopdu_pkg::PORT_UART_DATA: begin
                  // popping an empty fifo reads zero
                  fifo_ctl.pop = 1'b1;
                  rsp_in.rdata = fifo_stat.nonempty ? fifo_rdata : 8'h00;
               end
               default: begin
                  rsp_in.rdata = iopdu_pkg::RDATA_UNMAPPED;
               end
            endcase
         end
         iopdu_pkg::MODE_BUS_WRITE: begin
            case (item_ff.port)
               iopdu_pkg::PORT_STATUS: begin
                  if (!is_busy) begin
                     if (item_ff.wdata == iopdu_pkg::CMD_READ ||
                         item_ff.wdata == iopdu_pkg::CMD_WRITE) begin
                        status_in = iopdu_pkg::ST_BUSY |
                                    ((item_ff.wdata == iopdu_pkg::CMD_WRITE) ?
                                     iopdu_pkg::ST_WRITE : iopdu_pkg::ST_READ);
                        rsp_in.xfer_request  = 1'b1;
                        rsp_in.xfer_write    = (item_ff.wdata == iopdu_pkg::CMD_WRITE);
                        rsp_in.xfer_drive    = drive_ff;
                        rsp_in.xfer_lba      = lba;
                        rsp_in.xfer_dma_addr = dma_addr;
                     end else begin
                        status_in = iopdu_pkg::ST_ERROR;
                     end
                  end
               end
               iopdu_pkg::PORT_DRIVE:   drive_in = item_ff.wdata;
               iopdu_pkg::PORT_TRACK:   track_in = item_ff.wdata;
               iopdu_pkg::PORT_SECT_LO: sector_in = {sector_ff[15:8], item_ff.wdata};
               iopdu_pkg::PORT_SECT_HI: sector_in = {item_ff.wdata, sector_ff[7:0]};
               iopdu_pkg::PORT_OFF_LO:  offset_in = {offset_ff[15:8], item_ff.wdata};
               iopdu_pkg::PORT_OFF_HI:  offset_in = {item_ff.wdata, offset_ff[7:0]};
               iopdu_pkg::PORT_SEG_LO:  segment_in = {segment_ff[15:8], item_ff.wdata};
               iopdu_pkg::PORT_SEG_HI:  segment_in = {item_ff.wdata, segment_ff[7:0]};
               iopdu_pkg::PORT_UART_DATA: begin
                  rsp_in.tx_valid = 1'b1;
                  rsp_in.tx_byte  = item_ff.wdata;
               end
               iopdu_pkg::PORT_NMI_OFF: begin
                  rsp_in.nmi_lower = 1'b1;
               end
               default: begin
               end
            endcase
         end
         iopdu_pkg::MODE_UART_RX: begin
            if (item_ff.wdata == ichar_ff) begin
               rsp_in.nmi_raise = 1'b1;
            end else begin
               // dropped by the fifo when full
               fifo_ctl.push = 1'b1;
            end
         end
         iopdu_pkg::MODE_XFER_DONE: begin
            if (is_busy) begin
               status_in = (item_ff.done_ok && drive_known) ?
                           iopdu_pkg::ST_READY : iopdu_pkg::ST_ERROR;
            end
         end
         default: begin
         end
      endcase
      if (!commit) begin
         fifo_ctl = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff  <= iopdu_pkg::ST_READY;
         drive_ff   <= '0;
         track_ff   <= '0;
         sector_ff  <= '0;
         offset_ff  <= '0;
         segment_ff <= '0;
      end else if (commit) begin
         status_ff  <= status_in;
         drive_ff   <= drive_in;
         track_ff   <= track_in;
         sector_ff  <= sector_in;
         offset_ff  <= offset_in;
         segment_ff <= segment_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   iopdu_rx_fifo #(
      .DEPTH (RX_DEPTH)
   ) u_rx_fifo (
      .clock (clock),
      .reset (reset),
      .ctl   (fifo_ctl),
      .wdata (item_ff.wdata),
      .rdata (fifo_rdata),
      .stat  (fifo_stat)
   );

`ifndef ASSERT_OFF
   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      commit && rsp_in.xfer_request |=> (status_ff & iopdu_pkg::ST_BUSY) != '0)
      else $error("disk not busy after a transfer request");

   a_commit_fills_output: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("executed item left no response beat");

   a_no_accept_while_exec: assert property (@(posedge clock) disable iff (reset)
      state_ff == iopdu_pkg::ST_EXEC |-> !req_ready)
      else $error("request accepted while an item executes");

   a_full_implies_nonempty: assert property (@(posedge clock) disable iff (reset)
      fifo_stat.full |-> fifo_stat.nonempty)
      else $error("fifo full and empty at once");
`endif

endmodule

`default_nettype wire
